[design/fpba_pkg.sv]
// Package for the fit-policy block allocator: sizes, codes, table entry type,
// and the command/status bundles between controller and datapath. No dependencies.
`default_nettype none
package fpba_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

  localparam int START_W = 25;
  localparam int BYTES_W = 22;
  localparam int SEG_W   = 26;
  localparam int KIB_W   = 16;

  localparam logic [BYTES_W-1:0] REQ_MIN     = 22'd128;
  localparam logic [BYTES_W-1:0] REQ_MAX     = 22'd2097152;
  localparam logic [KIB_W-1:0]   SEG_KIB_MIN = 16'd32;
  localparam logic [KIB_W-1:0]   SEG_KIB_MAX = 16'd32768;
  localparam int                 KIB_SHIFT   = 10;

  typedef enum logic [0:0] {
    REG_SEGMENT_KIB = 1'b0,
    REG_FIT_METHOD  = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_GAP    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef enum logic [1:0] {
    RD_IDX  = 2'd0,
    RD_JM1  = 2'd1,
    RD_JP1  = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_GAP_RD, S_GAP_EV, S_PLACE, S_INS_RD, S_INS_WR,
    S_INS_PUT, S_FIND_RD, S_FIND_EV, S_DEL_RD, S_DEL_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    gap_eval;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ins_init;
    logic    del_init;
    logic    j_dec;
    logic    j_inc;
    logic    wr_up;
    logic    wr_dn;
    logic    put;
    logic    cnt_dec;
    logic    set_res;
    status_t res_code;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic size_bad;
    logic full;
    logic cnt_zero;
    logic idx_last;
    logic idx_next_last;
    logic hit;
    logic found;
    logic j_at_pick;
    logic j_next_end;
  } stat_t;

endpackage
`default_nettype wire

[design/fpba_ctrl.sv]
// Sequencer for the block allocator: steps the gap scan, table shifts and result.
// Depends on fpba_pkg.
`default_nettype none
module fpba_ctrl import fpba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.res_code = ST_OK;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_init = 1'b1;
        if (st.is_release) begin
          if (st.cnt_zero) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = ST_NOT_FOUND;
            state_next   = S_DONE;
          end else begin
            state_next = S_FIND_RD;
          end
        end else if (st.size_bad) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_BAD_SIZE;
          state_next   = S_DONE;
        end else if (st.full) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_DONE;
        end else begin
          state_next = S_GAP_RD;
        end
      end
      S_GAP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_GAP_EV;
      end
      S_GAP_EV: begin
        cmd.gap_eval = 1'b1;
        if (st.idx_last) begin
          state_next = S_PLACE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_GAP_RD;
        end
      end
      S_PLACE: begin
        if (!st.found) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NO_GAP;
          state_next   = S_DONE;
        end else begin
          cmd.ins_init = 1'b1;
          state_next   = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (st.j_at_pick) begin
          state_next = S_INS_PUT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JM1;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_up  = 1'b1;
        cmd.j_dec  = 1'b1;
        state_next = S_INS_RD;
      end
      S_INS_PUT: begin
        cmd.put      = 1'b1;
        cmd.set_res  = 1'b1;
        cmd.res_code = ST_OK;
        state_next   = S_DONE;
      end
      S_FIND_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_FIND_EV;
      end
      S_FIND_EV: begin
        if (st.hit) begin
          cmd.del_init = 1'b1;
          state_next   = S_DEL_RD;
        end else if (st.idx_next_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
          state_next   = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FIND_RD;
        end
      end
      S_DEL_RD: begin
        if (st.j_next_end) begin
          cmd.cnt_dec  = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_OK;
          state_next   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JP1;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_dn  = 1'b1;
        cmd.j_inc  = 1'b1;
        state_next = S_DEL_RD;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/fpba_datapath.sv]
// Datapath for the block allocator: block table memory, scan registers, config
// and result registers. Depends on fpba_pkg.
`default_nettype none
module fpba_datapath import fpba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [KIB_W-1:0]    cfg_data,
  input  logic                op,
  input  logic [BYTES_W-1:0]  request_size,
  input  logic [START_W-1:0]  release_offset,
  input  cmd_t                cmd,
  output stat_t               st,
  output logic [2:0]          status,
  output logic [START_W-1:0]  payload_offset
);

  entry_t mem [MAX_BLOCKS];
  entry_t rd;

  logic [KIB_W-1:0]   seg_kib;
  logic [1:0]         method;
  logic [CNT_W-1:0]   count;
  logic               op_q;
  logic [BYTES_W-1:0] req_q;
  logic [START_W-1:0] rel_q;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   j;
  logic [CNT_W-1:0]   pick;
  logic [SEG_W-1:0]   prev_end;
  logic [SEG_W-1:0]   pick_begin;
  logic [SEG_W-1:0]   pick_size;
  logic               found;

  logic [KIB_W-1:0]   kib_c;
  logic [SEG_W-1:0]   seg_bytes;
  logic [SEG_W-1:0]   gap_end;
  logic [SEG_W-1:0]   gap;
  logic [SEG_W-1:0]   need;
  logic [SEG_W-1:0]   blk_end;
  logic               fits;
  logic               take;
  logic [CNT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   jm1;
  logic [CNT_W-1:0]   jp1;

  always_comb begin
    kib_c = seg_kib;
    if (seg_kib < SEG_KIB_MIN) kib_c = SEG_KIB_MIN;
    if (seg_kib > SEG_KIB_MAX) kib_c = SEG_KIB_MAX;
  end
  assign seg_bytes = {{(SEG_W-KIB_W){1'b0}}, kib_c} << KIB_SHIFT;

  assign need    = {{(SEG_W-BYTES_W){1'b0}}, req_q} + SEG_W'(HEADER_BYTES);
  assign blk_end = {1'b0, rd.start} + SEG_W'(HEADER_BYTES)
                 + {{(SEG_W-BYTES_W){1'b0}}, rd.bytes};
  assign gap_end = (idx == count) ? seg_bytes : {1'b0, rd.start};
  assign gap     = (gap_end >= prev_end) ? gap_end - prev_end : '0;
  assign fits    = gap >= need;

  always_comb begin
    case (method)
      FIT_FIRST: take = fits && !found;
      FIT_BEST:  take = fits && (!found || gap <= pick_size);
      FIT_WORST: take = fits && (!found || gap >= pick_size);
      default:   take = 1'b0;
    endcase
  end

  assign jm1 = j - CNT_W'(1);
  assign jp1 = j + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_JM1:  rd_addr = jm1;
      RD_JP1:  rd_addr = jp1;
      default: rd_addr = idx;
    endcase
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd <= mem[rd_addr[IDX_W-1:0]];
    end
    if (cmd.wr_up || cmd.wr_dn) begin
      mem[j[IDX_W-1:0]] <= rd;
    end else if (cmd.put) begin
      mem[pick[IDX_W-1:0]] <= '{start: pick_begin[START_W-1:0], bytes: req_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_kib <= SEG_KIB_MIN;
      method  <= FIT_FIRST;
      count   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SEGMENT_KIB) begin
        seg_kib <= cfg_data;
        count   <= '0;
      end else if (cfg_we && cfg_index == REG_FIT_METHOD) begin
        method <= cfg_data[1:0];
      end
      if (cmd.put) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      req_q <= request_size;
      rel_q <= release_offset;
    end
    if (cmd.scan_init) begin
      idx      <= '0;
      prev_end <= SEG_W'(HEADER_BYTES);
      found    <= 1'b0;
    end
    if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.gap_eval) begin
      prev_end <= blk_end;
      if (take) begin
        found      <= 1'b1;
        pick       <= idx;
        pick_begin <= prev_end;
        pick_size  <= gap;
      end
    end
    if (cmd.ins_init) begin
      j <= count;
    end else if (cmd.del_init) begin
      j <= idx;
    end else if (cmd.j_dec) begin
      j <= jm1;
    end else if (cmd.j_inc) begin
      j <= jp1;
    end
    if (cmd.set_res) begin
      status         <= cmd.res_code;
      payload_offset <= (cmd.res_code == ST_OK && !op_q)
                      ? pick_begin[START_W-1:0] + START_W'(HEADER_BYTES) : '0;
    end
  end

  assign st.is_release    = (op_q == OP_RELEASE);
  assign st.size_bad      = (req_q < REQ_MIN) || (req_q > REQ_MAX);
  assign st.full          = (count == CNT_W'(MAX_BLOCKS));
  assign st.cnt_zero      = (count == '0);
  assign st.idx_last      = (idx == count);
  assign st.idx_next_last = (idx + CNT_W'(1) == count);
  assign st.hit           = ({1'b0, rd.start} + SEG_W'(HEADER_BYTES)) == {1'b0, rel_q};
  assign st.found         = found;
  assign st.j_at_pick     = (j == pick);
  assign st.j_next_end    = (jp1 == count);

endmodule
`default_nettype wire

[design/fit_policy_block_allocator.sv]
// Top level of the fit-policy block allocator: joins the sequencer and datapath.
// Depends on fpba_pkg, fpba_ctrl and fpba_datapath.
//
// Allocates and releases blocks in one segment kept as an address-ordered table
// of up to MAX_BLOCKS entries in a table memory with one write port and one
// registered read port. One request is in flight at a time. An allocate walks
// every gap (memory read, then compare), then shifts the entries above the
// chosen gap up by one (read, then write) and writes the new entry. A release
// searches up to the matching entry (read, then compare), then shifts the rest
// down (read, then write). Size errors, a full table and a release on an empty
// table are decided in the check state, with no scan. The result stays in the
// output register until taken; writing segment_kib empties the table.
`default_nettype none
module fit_policy_block_allocator import fpba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [KIB_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                op,
  input  logic [BYTES_W-1:0]  request_size,
  input  logic [START_W-1:0]  release_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [START_W-1:0]  payload_offset
);

  cmd_t  cmd;
  stat_t st;

  // Sequencer: hold the request, advance the scan and shifts.
  fpba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table, gap arithmetic and result registers.
  fpba_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .request_size   (request_size),
    .release_offset (release_offset),
    .cmd            (cmd),
    .st             (st),
    .status         (status),
    .payload_offset (payload_offset)
  );

endmodule
`default_nettype wire
